// ===== rtl/direct_mapped_writeback_cache_unit_assert.svh =====
// Assertion macros for the direct-mapped write-back cache unit.
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_UNIT_ASSERT_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_UNIT_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define DMWC_ASSERT_NOW(lbl, clk, rst, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// Condition implies consequence in the next cycle.
`define DMWC_ASSERT_NEXT(lbl, clk, rst, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

// ===== rtl/dmwc_pkg.sv =====
// Shared types and constants of the direct-mapped write-back cache unit.
package dmwc_pkg;

  localparam int ADDR_W = 11;
  localparam int BYTE_W = 8;

  // Request kind codes
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_WB,
    S_FILL,
    S_FIN
  } state_t;

  // Strobes to the cache arrays
  typedef struct packed {
    logic data_rd;
    logic data_wr;
    logic meta_rd;
    logic meta_wr;
  } arr_ctl_t;

  // Strobes to the backing memory
  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

  // Tag width left over from the address; at least one bit.
  function automatic int tag_w(input int off_w, input int idx_w);
    int r;
    r = (ADDR_W > off_w + idx_w) ? (ADDR_W - off_w - idx_w) : 1;
    return r;
  endfunction

endpackage

// ===== rtl/dmwc_backing.sv =====
// Backing memory with a one-entry-per-cycle initialization sweep after reset.
module dmwc_backing #(
  parameter int MEMORY_BYTES = 2048
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  dmwc_pkg::mem_ctl_t                       ctl,
  input  logic [$clog2(MEMORY_BYTES)-1:0]          rd_addr,
  input  logic [$clog2(MEMORY_BYTES)-1:0]          wr_addr,
  input  logic [dmwc_pkg::BYTE_W-1:0]              wr_byte,
  output logic [dmwc_pkg::BYTE_W-1:0]              rd_byte,
  output logic                                     ready
);

  localparam int MEM_W  = $clog2(MEMORY_BYTES);
  localparam int BYTE_W = dmwc_pkg::BYTE_W;
  localparam logic [MEM_W-1:0] LAST = MEM_W'(MEMORY_BYTES - 1);

  logic [BYTE_W-1:0] mem [MEMORY_BYTES];
  logic [MEM_W-1:0]  clr_addr;
  logic              clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + MEM_W'(1);
      if (clr_addr == LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  // Entry i starts out as the low byte of i
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= clr_addr[BYTE_W-1:0];
    end else if (ctl.wr) begin
      mem[wr_addr] <= wr_byte;
    end
    if (ctl.rd) begin
      rd_byte <= mem[rd_addr];
    end
  end

  assign ready = !clearing;

endmodule

// ===== rtl/dmwc_arrays.sv =====
// Cache line data array, tag/dirty array and per-line valid bits.
module dmwc_arrays #(
  parameter int LINES      = 16,
  parameter int LINE_BYTES = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  dmwc_pkg::arr_ctl_t                     ctl,
  input  logic [$clog2(LINES)-1:0]               meta_rd_idx,
  input  logic [$clog2(LINES)-1:0]               meta_wr_idx,
  input  logic [dmwc_pkg::tag_w($clog2(LINE_BYTES), $clog2(LINES))-1:0] meta_wr_tag,
  input  logic                                   meta_wr_dirty,
  input  logic [$clog2(LINES*LINE_BYTES)-1:0]    data_rd_addr,
  input  logic [$clog2(LINES*LINE_BYTES)-1:0]    data_wr_addr,
  input  logic [dmwc_pkg::BYTE_W-1:0]            data_wr_byte,
  output logic [dmwc_pkg::BYTE_W-1:0]            data_q,
  output logic [dmwc_pkg::tag_w($clog2(LINE_BYTES), $clog2(LINES))-1:0] tag_q,
  output logic                                   dirty_q,
  output logic                                   valid_q
);

  localparam int OFF_W  = $clog2(LINE_BYTES);
  localparam int IDX_W  = $clog2(LINES);
  localparam int TAG_W  = dmwc_pkg::tag_w(OFF_W, IDX_W);
  localparam int BYTE_W = dmwc_pkg::BYTE_W;

  logic [BYTE_W-1:0] data_mem [LINES*LINE_BYTES];
  logic [TAG_W:0]    meta_mem [LINES];   // {dirty, tag}
  logic [LINES-1:0]  valid;
  logic [TAG_W:0]    meta_rd;

  always_ff @(posedge clk) begin
    if (ctl.data_wr) begin
      data_mem[data_wr_addr] <= data_wr_byte;
    end
    if (ctl.data_rd) begin
      data_q <= data_mem[data_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.meta_wr) begin
      meta_mem[meta_wr_idx] <= {meta_wr_dirty, meta_wr_tag};
    end
    if (ctl.meta_rd) begin
      meta_rd <= meta_mem[meta_rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (ctl.meta_wr) begin
        valid[meta_wr_idx] <= 1'b1;
      end
      if (ctl.meta_rd) begin
        valid_q <= valid[meta_rd_idx];
      end
    end
  end

  // An invalid line reads as tag 0, clean
  assign tag_q   = valid_q ? meta_rd[TAG_W-1:0] : '0;
  assign dirty_q = valid_q & meta_rd[TAG_W];

endmodule

// ===== rtl/direct_mapped_writeback_cache_unit.sv =====
// Top level: direct-mapped write-back write-allocate byte cache with backing memory.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------
//  req     | in  | req_valid/req_stall| kind, address, write_data
//  rsp     | out | rsp_valid/rsp_stall| data_byte, hit, was_write
//
// A hit completes from the lookup; a clean miss also refills the line from
// backing memory, and a dirty miss first writes the victim line back.
// Line data and backing memory have byte-wide ports, so lines move byte by byte.
// After reset the backing memory is initialized one entry per cycle, and no
// request is taken until every entry has been written.
// A stalled result holds in the output register; the next request waits for idle.
`include "direct_mapped_writeback_cache_unit_assert.svh"

module direct_mapped_writeback_cache_unit #(
  parameter int LINES        = 16,
  parameter int LINE_BYTES   = 16,
  parameter int MEMORY_BYTES = 2048
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic                            kind,
  input  logic [dmwc_pkg::ADDR_W-1:0]     address,
  input  logic [dmwc_pkg::BYTE_W-1:0]     write_data,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [dmwc_pkg::BYTE_W-1:0]     data_byte,
  output logic                            hit,
  output logic                            was_write
);

  localparam int ADDR_W = dmwc_pkg::ADDR_W;
  localparam int BYTE_W = dmwc_pkg::BYTE_W;
  localparam int OFF_W  = $clog2(LINE_BYTES);
  localparam int IDX_W  = $clog2(LINES);
  localparam int TAG_W  = dmwc_pkg::tag_w(OFF_W, IDX_W);
  localparam int SLOT_W = IDX_W + OFF_W;
  localparam int MEM_W  = $clog2(MEMORY_BYTES);
  localparam int CNT_W  = OFF_W + 1;
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(LINE_BYTES);

  dmwc_pkg::state_t   state, state_next;
  dmwc_pkg::arr_ctl_t arr_ctl;
  dmwc_pkg::mem_ctl_t mem_ctl;

  // Address split of the incoming request (address wraps at memory size)
  logic [ADDR_W-1:0] addr_m;
  logic [OFF_W-1:0]  in_off;
  logic [IDX_W-1:0]  in_idx;
  logic [TAG_W-1:0]  in_tag;

  // Latched request
  logic              req_kind;
  logic [OFF_W-1:0]  req_off;
  logic [IDX_W-1:0]  req_idx;
  logic [TAG_W-1:0]  req_tag;
  logic [BYTE_W-1:0] req_data;

  // Line transfer sequencing: cnt issues reads, pend/pend_off retire writes
  logic [CNT_W-1:0]  cnt;
  logic              pend;
  logic [OFF_W-1:0]  pend_off;
  logic              hit_q;
  logic [BYTE_W-1:0] res_byte;

  // Array and memory hookup
  logic [SLOT_W-1:0] data_rd_addr, data_wr_addr;
  logic [BYTE_W-1:0] data_wr_byte, data_q;
  logic [TAG_W-1:0]  tag_q;
  logic              dirty_q, valid_q;
  logic              meta_wr_dirty;
  logic [MEM_W-1:0]  mem_rd_addr, mem_wr_addr;
  logic [BYTE_W-1:0] mem_rd_byte;
  logic              mem_ready;

  logic              accept;
  logic              lookup_hit;
  logic              rsp_free;
  logic              xfer_done;

  assign addr_m = ADDR_W'(MEM_W'(address));
  assign in_off = OFF_W'(addr_m);
  assign in_idx = IDX_W'(addr_m >> OFF_W);
  assign in_tag = TAG_W'(addr_m >> SLOT_W);

  assign req_stall  = (state != dmwc_pkg::S_IDLE) || !mem_ready;
  assign accept     = req_valid && !req_stall;
  assign lookup_hit = valid_q && (tag_q == req_tag);
  assign rsp_free   = !rsp_valid || !rsp_stall;
  assign xfer_done  = (cnt == CNT_END);

  // Victim write-back goes to the old tag's line; refill reads the new one.
  assign mem_wr_addr   = MEM_W'({tag_q, req_idx, pend_off});
  assign mem_rd_addr   = MEM_W'({req_tag, req_idx, cnt[OFF_W-1:0]});
  assign meta_wr_dirty = (req_kind == dmwc_pkg::KIND_WRITE) || (hit_q && dirty_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmwc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    arr_ctl      = '0;
    mem_ctl      = '0;
    data_rd_addr = {req_idx, cnt[OFF_W-1:0]};
    data_wr_addr = {req_idx, pend_off};
    data_wr_byte = mem_rd_byte;
    unique case (state)
      dmwc_pkg::S_IDLE: begin
        // Tag and data are read together; a hit needs no second access
        data_rd_addr    = {in_idx, in_off};
        arr_ctl.data_rd = accept;
        arr_ctl.meta_rd = accept;
        if (accept) begin
          state_next = dmwc_pkg::S_LOOKUP;
        end
      end
      dmwc_pkg::S_LOOKUP: begin
        priority if (lookup_hit) begin
          state_next = dmwc_pkg::S_FIN;
        end else if (dirty_q) begin
          state_next = dmwc_pkg::S_WB;
        end else begin
          state_next = dmwc_pkg::S_FILL;
        end
      end
      dmwc_pkg::S_WB: begin
        // Read line byte cnt, write the byte read in the previous cycle
        arr_ctl.data_rd = !xfer_done;
        mem_ctl.wr      = pend;
        if (xfer_done) begin
          state_next = dmwc_pkg::S_FILL;
        end
      end
      dmwc_pkg::S_FILL: begin
        mem_ctl.rd      = !xfer_done;
        arr_ctl.data_wr = pend;
        if (xfer_done) begin
          state_next = dmwc_pkg::S_FIN;
        end
      end
      dmwc_pkg::S_FIN: begin
        // Writes here repeat harmlessly while the output register is full
        arr_ctl.meta_wr = 1'b1;
        arr_ctl.data_wr = (req_kind == dmwc_pkg::KIND_WRITE);
        data_wr_addr    = {req_idx, req_off};
        data_wr_byte    = req_data;
        if (rsp_free) begin
          state_next = dmwc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dmwc_pkg::S_IDLE;
      end
    endcase
  end

  // Request latch, lookup result capture and transfer counters
  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind <= kind;
      req_off  <= in_off;
      req_idx  <= in_idx;
      req_tag  <= in_tag;
      req_data <= write_data;
    end
    if (state == dmwc_pkg::S_LOOKUP) begin
      hit_q    <= lookup_hit;
      res_byte <= data_q;
    end
    // Catch the requested byte as it streams in from memory
    if (state == dmwc_pkg::S_FILL && pend && pend_off == req_off) begin
      res_byte <= mem_rd_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      pend     <= 1'b0;
      pend_off <= '0;
    end else if (state == dmwc_pkg::S_WB || state == dmwc_pkg::S_FILL) begin
      pend_off <= cnt[OFF_W-1:0];
      if (xfer_done) begin
        cnt  <= '0;
        pend <= 1'b0;
      end else begin
        cnt  <= cnt + CNT_W'(1);
        pend <= 1'b1;
      end
    end else begin
      cnt  <= '0;
      pend <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == dmwc_pkg::S_FIN && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == dmwc_pkg::S_FIN && rsp_free) begin
      data_byte <= (req_kind == dmwc_pkg::KIND_WRITE) ? req_data : res_byte;
      hit       <= hit_q;
      was_write <= req_kind;
    end
  end

  dmwc_arrays #(
    .LINES      (LINES),
    .LINE_BYTES (LINE_BYTES)
  ) u_arrays (
    .clk           (clk),
    .rst           (rst),
    .ctl           (arr_ctl),
    .meta_rd_idx   (in_idx),
    .meta_wr_idx   (req_idx),
    .meta_wr_tag   (req_tag),
    .meta_wr_dirty (meta_wr_dirty),
    .data_rd_addr  (data_rd_addr),
    .data_wr_addr  (data_wr_addr),
    .data_wr_byte  (data_wr_byte),
    .data_q        (data_q),
    .tag_q         (tag_q),
    .dirty_q       (dirty_q),
    .valid_q       (valid_q)
  );

  dmwc_backing #(
    .MEMORY_BYTES (MEMORY_BYTES)
  ) u_backing (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mem_ctl),
    .rd_addr (mem_rd_addr),
    .wr_addr (mem_wr_addr),
    .wr_byte (data_q),
    .rd_byte (mem_rd_byte),
    .ready   (mem_ready)
  );

  // An accepted transaction always goes to tag lookup next
  `DMWC_ASSERT_NEXT(a_accept_lookup, clk, rst, accept, state == dmwc_pkg::S_LOOKUP, "accept without lookup")
  // A result only appears from the finish state
  `DMWC_ASSERT_NEXT(a_rsp_source, clk, rst, !rsp_valid && state != dmwc_pkg::S_FIN, !rsp_valid, "result outside finish")
  // The backing memory write strobe is raised only during victim write-back
  `DMWC_ASSERT_NOW(a_wb_only, clk, rst, mem_ctl.wr, state == dmwc_pkg::S_WB && mem_ready, "stray memory write")

endmodule

// ===== tb/tb_direct_mapped_writeback_cache_unit.sv =====
// Self-checking testbench for the direct-mapped write-back cache unit.
`timescale 1ns / 1ps

module tb_direct_mapped_writeback_cache_unit;

  localparam int ADDR_W = dmwc_pkg::ADDR_W;
  localparam int BYTE_W = dmwc_pkg::BYTE_W;

  // Geometry at the default parameters: offset 3:0, line 7:4, tag 10:8
  localparam int OFF_W     = 4;
  localparam int LINE_W    = 4;
  localparam int TAG_W     = 3;
  localparam int NUM_LINES = 16;
  localparam int LINE_LEN  = 16;
  localparam int BACKING_BYTES = 2048;

  localparam int RANDOM_REQS = 800;
  localparam int TAIL_REQS   = 100;    // no idling on either side this close to the end
  localparam int HOLD_AT     = 250;    // request count that starts the long response hold
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 60;    // covers a dirty miss, plus margin
  // Cycles with no transaction on either channel before giving up; covers the
  // memory init after reset and the long hold with wide margin.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] write_data;
  } cache_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              hit;
    logic              was_write;
  } cache_rsp_t;

  // DUT signals; every input starts at a known value
  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              req_valid  = 1'b0;
  logic              req_stall;
  logic              kind       = dmwc_pkg::KIND_READ;
  logic [ADDR_W-1:0] address    = '0;
  logic [BYTE_W-1:0] write_data = '0;
  logic              rsp_valid;
  logic              rsp_stall  = 1'b0;
  logic [BYTE_W-1:0] data_byte;
  logic              hit;
  logic              was_write;

  direct_mapped_writeback_cache_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .kind       (kind),
    .address    (address),
    .write_data (write_data),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .data_byte  (data_byte),
    .hit        (hit),
    .was_write  (was_write)
  );

  always #2 clk = ~clk;

  // Shadow copy of the cache and its backing memory
  logic              shadow_valid [NUM_LINES];
  logic              shadow_dirty [NUM_LINES];
  logic [TAG_W-1:0]  shadow_tag   [NUM_LINES];
  logic [BYTE_W-1:0] shadow_bytes [NUM_LINES*LINE_LEN];
  logic [BYTE_W-1:0] shadow_mem   [BACKING_BYTES];

  cache_req_t pending_reqs[$];     // requests not yet offered
  cache_rsp_t expected_rsps[$];    // predicted responses, oldest first

  int total_reqs    = 0;
  int reqs_accepted = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;           // cycles since the last transaction on either side
  int cycle_count   = 0;
  bit idle_phase    = 1'b1;        // random idling allowed in the current stretch
  bit long_hold     = 1'b0;        // response side is in its long hold-off
  int send_gap      = 0;
  int stall_left    = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;

  function automatic bit in_tail();
    return reqs_accepted >= total_reqs - TAIL_REQS;
  endfunction

  task automatic note_failure(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, what);
  endtask

  task automatic reset_shadow();
    int i;
    for (i = 0; i < NUM_LINES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_dirty[i] = 1'b0;
      shadow_tag[i]   = '0;
    end
    for (i = 0; i < NUM_LINES*LINE_LEN; i++) shadow_bytes[i] = '0;
    for (i = 0; i < BACKING_BYTES; i++) shadow_mem[i] = i[BYTE_W-1:0];
  endtask

  // Apply one accepted request to the shadow cache and queue its response.
  // Miss: write back a dirty victim, refill the whole line, then the byte op.
  task automatic predict_access(input cache_req_t rq);
    logic [OFF_W-1:0]  off;
    logic [LINE_W-1:0] ln;
    logic [TAG_W-1:0]  tg;
    logic              is_hit;
    cache_rsp_t        rsp;
    int                i;
    off    = rq.address[OFF_W-1:0];
    ln     = rq.address[OFF_W +: LINE_W];
    tg     = rq.address[ADDR_W-1 -: TAG_W];
    is_hit = shadow_valid[ln] && (shadow_tag[ln] == tg);
    if (!is_hit) begin
      if (shadow_valid[ln] && shadow_dirty[ln]) begin
        for (i = 0; i < LINE_LEN; i++)
          shadow_mem[{shadow_tag[ln], ln, i[OFF_W-1:0]}] = shadow_bytes[{ln, i[OFF_W-1:0]}];
        shadow_dirty[ln] = 1'b0;
      end
      for (i = 0; i < LINE_LEN; i++)
        shadow_bytes[{ln, i[OFF_W-1:0]}] = shadow_mem[{tg, ln, i[OFF_W-1:0]}];
      shadow_tag[ln]   = tg;
      shadow_valid[ln] = 1'b1;
    end
    if (rq.kind == dmwc_pkg::KIND_WRITE) begin
      shadow_bytes[{ln, off}] = rq.write_data;
      shadow_dirty[ln]        = 1'b1;
      rsp.data_byte           = rq.write_data;
    end else begin
      rsp.data_byte = shadow_bytes[{ln, off}];
    end
    rsp.hit       = is_hit;
    rsp.was_write = rq.kind;
    expected_rsps.push_back(rsp);
  endtask

  task automatic queue_req(input logic k, input logic [ADDR_W-1:0] a,
                           input logic [BYTE_W-1:0] d);
    cache_req_t rq;
    rq.kind       = k;
    rq.address    = a;
    rq.write_data = d;
    pending_reqs.push_back(rq);
  endtask

  // Directed corner cases, then random traffic around a few hot tags and
  // lines so that hits, clean misses and dirty evictions all occur often.
  task automatic build_stimulus();
    logic [TAG_W-1:0]  hot_tag [2];
    logic [LINE_W-1:0] hot_line;
    logic [TAG_W-1:0]  tg;
    logic [LINE_W-1:0] ln;
    logic [ADDR_W-1:0] a;
    logic [BYTE_W-1:0] d;
    int                n;
    int                next_shuffle;
    int                sel;
    // cold misses at both address extremes
    queue_req(dmwc_pkg::KIND_READ,  11'h000, 8'hFF);   // read ignores write data
    queue_req(dmwc_pkg::KIND_READ,  11'h7FF, 8'h00);
    // write hits with data extremes, read back
    queue_req(dmwc_pkg::KIND_WRITE, 11'h7FF, 8'hFF);
    queue_req(dmwc_pkg::KIND_WRITE, 11'h7F0, 8'h00);
    queue_req(dmwc_pkg::KIND_READ,  11'h7FF, 8'hAA);
    queue_req(dmwc_pkg::KIND_READ,  11'h7F0, 8'h55);
    // dirty line 0 evicted by another tag, then brought back from memory
    queue_req(dmwc_pkg::KIND_WRITE, 11'h00F, 8'hA5);
    queue_req(dmwc_pkg::KIND_READ,  11'h10F, 8'h00);
    queue_req(dmwc_pkg::KIND_READ,  11'h00F, 8'h00);
    // write miss into an empty line, then a dirty write miss on the same line
    queue_req(dmwc_pkg::KIND_WRITE, 11'h355, 8'h5A);
    queue_req(dmwc_pkg::KIND_WRITE, 11'h455, 8'hC3);
    queue_req(dmwc_pkg::KIND_READ,  11'h355, 8'h00);
    queue_req(dmwc_pkg::KIND_READ,  11'h455, 8'h00);
    queue_req(dmwc_pkg::KIND_WRITE, 11'h2AA, 8'h55);
    queue_req(dmwc_pkg::KIND_WRITE, 11'h2AB, 8'hAA);
    queue_req(dmwc_pkg::KIND_READ,  11'h2AA, 8'h00);
    queue_req(dmwc_pkg::KIND_READ,  11'h5AB, 8'h00);
    queue_req(dmwc_pkg::KIND_READ,  11'h2AB, 8'h00);
    // dirty line 15 with top tag evicted by tag 0
    queue_req(dmwc_pkg::KIND_READ,  11'h0F0, 8'h00);
    queue_req(dmwc_pkg::KIND_READ,  11'h7FF, 8'h00);

    n            = 0;
    next_shuffle = 0;
    hot_tag[0]   = '0;
    hot_tag[1]   = '0;
    hot_line     = '0;
    while (n < RANDOM_REQS) begin
      if (n >= next_shuffle) begin
        hot_tag[0]   = TAG_W'($urandom_range(0, 7));
        hot_tag[1]   = TAG_W'($urandom_range(0, 7));
        hot_line     = LINE_W'($urandom_range(0, 15));
        next_shuffle = n + 100;
      end
      sel = $urandom_range(0, 99);
      d   = BYTE_W'($urandom_range(0, 255));
      if (sel < 15) begin
        a = ADDR_W'($urandom_range(0, BACKING_BYTES-1));
      end else begin
        tg = hot_tag[$urandom_range(0, 1)];
        ln = hot_line + LINE_W'($urandom_range(0, 3));
        a  = {tg, ln, OFF_W'($urandom_range(0, 15))};
      end
      if (sel >= 15 && sel < 45) begin
        // store then load of the same byte
        queue_req(dmwc_pkg::KIND_WRITE, a, d);
        queue_req(dmwc_pkg::KIND_READ,  a, BYTE_W'($urandom_range(0, 255)));
        n += 2;
      end else begin
        queue_req(1'($urandom_range(0, 1)), a, d);
        n++;
      end
    end
  endtask

  // Request driver: one nonblocking write per signal per edge
  always @(posedge clk) begin
    cache_req_t rq;
    bit         offering;
    bit         allow_idle;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      offering = req_valid;
      if (req_valid && !req_stall) begin
        rq.kind       = kind;
        rq.address    = address;
        rq.write_data = write_data;
        predict_access(rq);
        reqs_accepted++;
        offering = 1'b0;
      end
      if (!offering) begin
        allow_idle = idle_phase && !long_hold && !in_tail();
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reqs.size() != 0) begin
          if (allow_idle && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 7);   // random idle gap before the next request
          end else begin
            rq = pending_reqs.pop_front();
            kind       <= rq.kind;
            address    <= rq.address;
            write_data <= rq.write_data;
            offering   = 1'b1;
          end
        end
      end
      req_valid <= offering;
    end
  end

  // Response side stall: short random bursts plus one long hold-off that
  // lets the unit fill its output register and back-pressure requests.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && reqs_accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (idle_phase && !in_tail() && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 8);
      end
      rsp_stall <= (hold_left > 0) || (stall_left > 0);
      long_hold <= (hold_left > 0);
    end
  end

  // Response checker
  always @(posedge clk) begin
    cache_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        note_failure($sformatf("response with none pending: data=%02h hit=%0b wr=%0b",
                               data_byte, hit, was_write));
      end else begin
        want = expected_rsps.pop_front();
        if (data_byte !== want.data_byte || hit !== want.hit || was_write !== want.was_write)
          note_failure($sformatf("data exp %02h got %02h, hit exp %0b got %0b, wr exp %0b got %0b",
                                 want.data_byte, data_byte, want.hit, hit,
                                 want.was_write, was_write));
      end
    end
  end

  // Watchdog count and idle-phase selection
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count % 256 == 0) idle_phase <= ($urandom_range(0, 3) != 0);
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    reset_shadow();
    build_stimulus();
    total_reqs = pending_reqs.size();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // checks run at the falling edge, after all rising-edge updates
    while (reqs_accepted < total_reqs && quiet_cycles < WATCHDOG_LIMIT) @(negedge clk);
    while (expected_rsps.size() != 0 && quiet_cycles < WATCHDOG_LIMIT) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: timeout, %0d of %0d requests taken, %0d responses outstanding",
               reqs_accepted, total_reqs, expected_rsps.size());
      mismatches++;
    end else if (expected_rsps.size() != 0) begin
      note_failure($sformatf("%0d responses never arrived", expected_rsps.size()));
    end
    if (mismatches == 0) begin
      $display("PASS direct_mapped_writeback_cache_unit");
    end else begin
      $display("FAIL direct_mapped_writeback_cache_unit");
    end
    $finish;
  end

endmodule
